@@ sv/u8dw_pkg.sv @@
// ----------------------------------------------------------------------------
// u8dw_pkg
// Shared types and constants for the UTF-8 decoder with cell width.
// ----------------------------------------------------------------------------
package u8dw_pkg;

  localparam int CP_W            = 21;
  localparam int BYTE_W          = 8;
  localparam int CELL_W          = 2;
  localparam int TOTAL_OUT_W     = 16;
  localparam int JOB_SLOTS       = 4;
  localparam int SLOT_IDX_W      = 2;
  localparam int TOTAL_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // one decoded byte's worth of results, handed from front to back
  typedef struct packed {
    logic [JOB_SLOTS-1:0][CP_W-1:0] cp;
    logic [JOB_SLOTS-1:0]           raw;
    logic [SLOT_IDX_W-1:0]          last_idx;
    logic                           str_end;
  } job_t;

endpackage

@@ sv/u8dw_front.sv @@
// ----------------------------------------------------------------------------
// u8dw_front
// Sequence tracking: takes one byte a cycle while accept is high and builds a
// job of up to four code points (decoded or raw) for the back end.
// ----------------------------------------------------------------------------
module u8dw_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [u8dw_pkg::BYTE_W-1:0] data_byte,
  input  logic                       string_end,
  output logic                       job_push,
  output u8dw_pkg::job_t             job
);

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN2     = 3'd2;
  localparam logic [2:0] LEN3     = 3'd3;
  localparam logic [2:0] LEN4     = 3'd4;

  localparam int CPW = u8dw_pkg::CP_W;

  logic [7:0] lead_r, lead_nxt;
  logic [2:0] exp_r, exp_nxt;
  logic [1:0] hcnt_r, hcnt_nxt;
  logic [7:0] held_r [2];
  logic [7:0] held_nxt [2];

  logic [2:0]     n;
  logic           fresh;
  logic           is_cont;
  logic [CPW-1:0] cp_dec;
  u8dw_pkg::job_t job_c;

  assign is_cont = (data_byte & CONT_MASK) == CONT_CODE;

  always_comb begin
    unique case (exp_r)
      LEN2:    cp_dec = {10'd0, lead_r[4:0], data_byte[5:0]};
      LEN3:    cp_dec = {5'd0, lead_r[3:0], held_r[0][5:0], data_byte[5:0]};
      default: cp_dec = {lead_r[2:0], held_r[0][5:0], held_r[1][5:0], data_byte[5:0]};
    endcase
  end

  always_comb begin
    lead_nxt    = lead_r;
    exp_nxt     = exp_r;
    hcnt_nxt    = hcnt_r;
    held_nxt[0] = held_r[0];
    held_nxt[1] = held_r[1];
    job_c       = '0;
    n           = 3'd0;
    fresh       = 1'b1;

    if (exp_r != LEN_NONE) begin
      if (is_cont) begin
        fresh = 1'b0;
        if ({1'b0, hcnt_r} + 3'd2 >= exp_r) begin
          job_c.cp[0]  = cp_dec;
          job_c.raw[0] = 1'b0;
          n            = 3'd1;
          lead_nxt     = '0;
          exp_nxt      = LEN_NONE;
          hcnt_nxt     = '0;
        end else begin
          held_nxt[hcnt_r[0]] = data_byte;
          hcnt_nxt            = hcnt_r + 2'd1;
        end
      end else begin
        // broken sequence: lead and held bytes go out raw
        job_c.cp[n[1:0]]  = CPW'(lead_r);
        job_c.raw[n[1:0]] = 1'b1;
        n                 = n + 3'd1;
        for (int i = 0; i < 2; i++) begin
          if (i < int'(hcnt_r)) begin
            job_c.cp[n[1:0]]  = CPW'(held_r[i]);
            job_c.raw[n[1:0]] = 1'b1;
            n                 = n + 3'd1;
          end
        end
        lead_nxt = '0;
        exp_nxt  = LEN_NONE;
        hcnt_nxt = '0;
      end
    end

    if (fresh) begin
      if (!data_byte[7]) begin
        job_c.cp[n[1:0]]  = CPW'(data_byte);
        job_c.raw[n[1:0]] = 1'b0;
        n                 = n + 3'd1;
      end else if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
        lead_nxt = data_byte;
        exp_nxt  = LEN2;
        hcnt_nxt = '0;
      end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
        lead_nxt = data_byte;
        exp_nxt  = LEN3;
        hcnt_nxt = '0;
      end else if ((data_byte & LEAD4_MASK) == LEAD4_CODE) begin
        lead_nxt = data_byte;
        exp_nxt  = LEN4;
        hcnt_nxt = '0;
      end else begin
        // stray continuation or invalid lead
        job_c.cp[n[1:0]]  = CPW'(data_byte);
        job_c.raw[n[1:0]] = 1'b1;
        n                 = n + 3'd1;
      end
    end

    // string ends inside a sequence
    if (string_end && exp_nxt != LEN_NONE) begin
      job_c.cp[n[1:0]]  = CPW'(lead_nxt);
      job_c.raw[n[1:0]] = 1'b1;
      n                 = n + 3'd1;
      for (int i = 0; i < 2; i++) begin
        if (i < int'(hcnt_nxt)) begin
          job_c.cp[n[1:0]]  = CPW'(held_nxt[i]);
          job_c.raw[n[1:0]] = 1'b1;
          n                 = n + 3'd1;
        end
      end
      lead_nxt = '0;
      exp_nxt  = LEN_NONE;
      hcnt_nxt = '0;
    end

    job_c.last_idx = 2'(n - 3'd1);
    job_c.str_end  = string_end;
  end

  assign job      = job_c;
  assign job_push = accept && (n != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= '0;
      exp_r  <= LEN_NONE;
      hcnt_r <= '0;
    end else if (accept) begin
      lead_r <= lead_nxt;
      exp_r  <= exp_nxt;
      hcnt_r <= hcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r[0] <= held_nxt[0];
      held_r[1] <= held_nxt[1];
    end
  end

endmodule

@@ sv/u8dw_queue.sv @@
// ----------------------------------------------------------------------------
// u8dw_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module u8dw_queue #(
  parameter int DEPTH = u8dw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  u8dw_pkg::job_t wr_job,
  output logic           q_full,
  input  logic           rd_en,
  output u8dw_pkg::job_t rd_job,
  output logic           q_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  u8dw_pkg::job_t   slots_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign q_full  = cnt_r == CNT_FULL;
  assign q_empty = cnt_r == '0;
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_job  = slots_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= (wptr_r == PTR_LAST) ? '0 : wptr_r + 1'b1;
      end
      if (do_rd) begin
        rptr_r <= (rptr_r == PTR_LAST) ? '0 : rptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ sv/u8dw_back.sv @@
// ----------------------------------------------------------------------------
// u8dw_back
// Walks each job one code point a cycle while the result register is free or
// being popped: cell width, saturating string total and the result register.
// ----------------------------------------------------------------------------
module u8dw_back #(
  parameter int TOTAL_WIDTH_BITS = u8dw_pkg::TOTAL_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  u8dw_pkg::job_t                   head_job,
  input  logic                             head_empty,
  output logic                             head_pop,
  input  logic                             pop,
  output logic                             empty,
  output logic [u8dw_pkg::CP_W-1:0]        code_point,
  output logic [u8dw_pkg::CELL_W-1:0]      cell_width,
  output logic [u8dw_pkg::TOTAL_OUT_W-1:0] total_width,
  output logic                             raw_fallback,
  output logic                             string_done,
  output logic                             last_of_run
);

  localparam int TW    = TOTAL_WIDTH_BITS;
  localparam int CPW   = u8dw_pkg::CP_W;
  localparam int EXT_W = (TW > u8dw_pkg::TOTAL_OUT_W) ? TW : u8dw_pkg::TOTAL_OUT_W;

  function automatic logic [1:0] cell_of(input logic [CPW-1:0] cp);
    logic wide;
    wide = (cp >= 21'h1100 && cp <= 21'h115F) ||
           (cp >= 21'h2329 && cp <= 21'h232A) ||
           (cp >= 21'h2E80 && cp <= 21'hA4CF && cp != 21'h303F) ||
           (cp >= 21'hAC00 && cp <= 21'hD7A3) ||
           (cp >= 21'hF900 && cp <= 21'hFAFF) ||
           (cp >= 21'hFE10 && cp <= 21'hFE19) ||
           (cp >= 21'hFE30 && cp <= 21'hFE6F) ||
           (cp >= 21'hFF00 && cp <= 21'hFF60) ||
           (cp >= 21'hFFE0 && cp <= 21'hFFE6);
    if (cp < 21'h20 || (cp >= 21'h7F && cp < 21'hA0)) begin
      return 2'd0;
    end else if (wide) begin
      return 2'd2;
    end
    return 2'd1;
  endfunction

  logic [u8dw_pkg::SLOT_IDX_W-1:0] idx_r;
  logic [TW-1:0]    sum_r;
  logic             valid_r;
  logic             adv;
  logic             is_last;
  logic [CPW-1:0]   cur_cp;
  logic [1:0]       cur_w;
  logic [TW:0]      sum_add;
  logic [TW-1:0]    sum_new;
  logic [EXT_W-1:0] sum_ext;

  assign adv     = !head_empty && (!valid_r || pop);
  assign cur_cp  = head_job.cp[idx_r];
  assign cur_w   = cell_of(cur_cp);
  assign is_last = idx_r == head_job.last_idx;
  assign sum_add = {1'b0, sum_r} + (TW + 1)'(cur_w);
  assign sum_new = sum_add[TW] ? '1 : sum_add[TW-1:0];
  assign sum_ext = EXT_W'(sum_new);

  assign head_pop = adv && is_last;
  assign empty    = !valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
      sum_r   <= '0;
    end else begin
      if (adv) begin
        valid_r <= 1'b1;
        idx_r   <= is_last ? '0 : idx_r + 1'b1;
        // the total starts afresh after the final word of a string
        sum_r   <= (is_last && head_job.str_end) ? '0 : sum_new;
      end else if (pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      code_point   <= cur_cp;
      cell_width   <= cur_w;
      total_width  <= sum_ext[u8dw_pkg::TOTAL_OUT_W-1:0];
      raw_fallback <= head_job.raw[idx_r];
      string_done  <= is_last && head_job.str_end;
      last_of_run  <= is_last;
    end
  end

endmodule

@@ sv/utf8_decode_display_width.sv @@
// ----------------------------------------------------------------------------
// utf8_decode_display_width
// UTF-8 decoder giving console cell width and a running string total.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle whenever the job queue has room. Each byte
// that completes a character, or breaks or ends a sequence, becomes a job of
// one to four result words; the back end hands out one result word a cycle
// while its output register is free or being popped, so the sustained rate is
// one byte a cycle while bytes average at most one result; a byte with more
// results holds the back end until each has gone out, and the QUEUE_DEPTH job
// queue absorbs such bursts. A word passes through the job queue and the
// output register, and the back end stalls while a word waits there unpopped.
module utf8_decode_display_width #(
  parameter int TOTAL_WIDTH_BITS = u8dw_pkg::TOTAL_WIDTH_DEF,
  parameter int QUEUE_DEPTH      = u8dw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic [u8dw_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic                             in_string_end,
  input  logic                             pop,
  output logic                             empty,
  output logic [u8dw_pkg::CP_W-1:0]        out_code_point,
  output logic [u8dw_pkg::CELL_W-1:0]      out_cell_width,
  output logic [u8dw_pkg::TOTAL_OUT_W-1:0] out_total_width,
  output logic                             out_raw_fallback,
  output logic                             out_string_done,
  output logic                             out_last_of_run
);

  logic           accept;
  logic           job_push;
  u8dw_pkg::job_t job_in;
  u8dw_pkg::job_t head_job;
  logic           head_empty;
  logic           head_pop;

  assign accept = push && !full;

  u8dw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .string_end (in_string_end),
    .job_push   (job_push),
    .job        (job_in)
  );

  u8dw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_job  (job_in),
    .q_full  (full),
    .rd_en   (head_pop),
    .rd_job  (head_job),
    .q_empty (head_empty)
  );

  u8dw_back #(
    .TOTAL_WIDTH_BITS (TOTAL_WIDTH_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_job     (head_job),
    .head_empty   (head_empty),
    .head_pop     (head_pop),
    .pop          (pop),
    .empty        (empty),
    .code_point   (out_code_point),
    .cell_width   (out_cell_width),
    .total_width  (out_total_width),
    .raw_fallback (out_raw_fallback),
    .string_done  (out_string_done),
    .last_of_run  (out_last_of_run)
  );

endmodule
